/* src/bbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the block buffer cache
// Function codes, default sizes and the word passed from front to back.
// ----------------------------------------------------------------------------
package bbc_pkg;
  localparam int DEFAULT_SLOTS = 16;
  localparam int HANDLE_W = 8;
  localparam int BLOCK_W = 24;
  localparam int ACTIVE_W = 5;
  localparam int COUNT_W = 5;
  localparam int SLOT_W = 4;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_INVAL = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // one classified request word
  typedef struct packed {
    func_t                 func;
    logic [HANDLE_W-1:0]   handle;
    logic [BLOCK_W-1:0]    block_number;
  } req_t;
endpackage

/* src/bbc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_front: request intake
// Accepts input words and queues them, two deep, for the back end.
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    func,
  input  logic [7:0]    handle,
  input  logic [23:0]   block_number,
  output logic          q_valid,
  input  logic          q_ready,
  output bbc_pkg::req_t q_word
);
  import bbc_pkg::*;

  req_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_word   = mem[rd_ptr];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= '{func: func_t'(func), handle: handle, block_number: block_number};
        wr_ptr <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* src/bbc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_back: slot lookup, FIFO replacement and invalidate
// Scans one slot a cycle over the tag store, then updates and reports.
// ----------------------------------------------------------------------------
module bbc_back #(
  parameter int SLOTS = bbc_pkg::DEFAULT_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [4:0]    active_buffers,
  input  logic          q_valid,
  output logic          q_ready,
  input  bbc_pkg::req_t q_word,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    slot,
  output logic          hit,
  output logic          fill_needed,
  output logic          evicted,
  output logic [7:0]    evict_handle,
  output logic [23:0]   evict_block,
  output logic          writeback_needed,
  output logic [4:0]    invalidated_count
);
  import bbc_pkg::*;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FILL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  req_t   req;
  logic [SLOTS-1:0] valid, dirty;
  logic [HANDLE_W-1:0] owner_mem [SLOTS];
  logic [BLOCK_W-1:0]  block_mem [SLOTS];
  logic [IW-1:0] idx, fifo_pointer, found_idx;
  logic          found;
  logic [CW-1:0] cleared;
  logic [CW:0]   n;
  logic [IW:0]   ptr_inc;
  logic [IW-1:0] victim;
  logic          tag_match;

  // clamp active count to 1..SLOTS
  always_comb begin
    if (active_buffers == 5'd0) n = (CW+1)'(1);
    else if (32'(active_buffers) > SLOTS) n = (CW+1)'(SLOTS);
    else n = (CW+1)'(active_buffers);
  end

  assign ptr_inc = {1'b0, fifo_pointer} + 1'b1;
  assign victim  = ((CW+1)'(ptr_inc) >= n) ? '0 : ptr_inc[IW-1:0];
  assign tag_match = valid[idx] && owner_mem[idx] == req.handle;
  assign q_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      dirty <= '0;
      fifo_pointer <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            req     <= q_word;
            idx     <= '0;
            found   <= 1'b0;
            cleared <= '0;
            state   <= (q_word.func == FUNC_NONE) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          // one slot per cycle
          if (req.func == FUNC_INVAL) begin
            if (tag_match && (CW+1)'(idx) < n) begin
              valid[idx] <= 1'b0;
              dirty[idx] <= 1'b0;
              cleared    <= cleared + 1'b1;
            end
          end else if (!found && tag_match && block_mem[idx] == req.block_number) begin
            found     <= 1'b1;
            found_idx <= idx;
          end
          if (32'(idx) == SLOTS - 1) state <= S_FILL;
          else idx <= idx + 1'b1;
        end
        S_FILL: begin
          if (req.func == FUNC_INVAL) begin
            slot <= '0; hit <= 1'b0; fill_needed <= 1'b0; evicted <= 1'b0;
            evict_handle <= '0; evict_block <= '0; writeback_needed <= 1'b0;
            invalidated_count <= (32'(cleared) > 31) ? 5'd31 : 5'(cleared);
          end else if (found) begin
            slot <= 4'(found_idx); hit <= 1'b1; fill_needed <= 1'b0; evicted <= 1'b0;
            evict_handle <= '0; evict_block <= '0; writeback_needed <= 1'b0;
            invalidated_count <= '0;
            if (req.func == FUNC_WRITE) dirty[found_idx] <= 1'b1;
          end else begin
            // miss: replace the next FIFO slot, report what it held
            fifo_pointer      <= victim;
            slot              <= 4'(victim);
            hit               <= 1'b0;
            fill_needed       <= 1'b1;
            evicted           <= valid[victim];
            evict_handle      <= valid[victim] ? owner_mem[victim] : '0;
            evict_block       <= valid[victim] ? block_mem[victim] : '0;
            writeback_needed  <= valid[victim] && dirty[victim];
            invalidated_count <= '0;
            valid[victim]     <= 1'b1;
            owner_mem[victim] <= req.handle;
            block_mem[victim] <= req.block_number;
            dirty[victim]     <= (req.func == FUNC_WRITE);
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_DONE: begin
          // unused code: all-zero result
          slot <= '0; hit <= 1'b0; fill_needed <= 1'b0; evicted <= 1'b0;
          evict_handle <= '0; evict_block <= '0; writeback_needed <= 1'b0;
          invalidated_count <= '0;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/block_buffer_cache_fifo_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_buffer_cache_fifo_unit: block buffer cache with FIFO replacement
// The back end takes a word, scans the tag store one slot per cycle and posts
// the result; it takes the next word only once that result is accepted, so it
// does not overlap words and waits while the output stalls. Unused function
// codes skip the scan. The front queue holds up to two more words meanwhile.
// Results are held in an output register until taken.
// ----------------------------------------------------------------------------
module block_buffer_cache_fifo_unit #(
  parameter int BUFFER_SLOTS = bbc_pkg::DEFAULT_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  handle,
  input  logic [23:0] block_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  slot,
  output logic        hit,
  output logic        fill_needed,
  output logic        evicted,
  output logic [7:0]  evict_handle,
  output logic [23:0] evict_block,
  output logic        writeback_needed,
  output logic [4:0]  invalidated_count
);
  import bbc_pkg::*;

  logic [4:0] active_buffers;
  logic       q_valid, q_ready;
  req_t       q_word;

  assign cfg_ready = 1'b1;
  // configuration register
  always_ff @(posedge clk) begin
    if (rst) active_buffers <= ACTIVE_RESET;
    else if (cfg_valid) active_buffers <= cfg_data;
  end

  bbc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .func, .handle, .block_number,
    .q_valid, .q_ready, .q_word
  );

  bbc_back #(.SLOTS(BUFFER_SLOTS)) u_back (
    .clk, .rst, .active_buffers, .q_valid, .q_ready, .q_word,
    .out_valid, .out_ready, .slot, .hit, .fill_needed, .evicted,
    .evict_handle, .evict_block, .writeback_needed, .invalidated_count
  );
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the block buffer cache
// A queue of access words feeds a clocked driver; a clocked monitor compares
// each result against a cache predictor run at input acceptance. Phases step
// through idle/stall mixes and active-buffer settings, including a long
// output hold-off that backs the cache up.
// ----------------------------------------------------------------------------
module tb_top;
  import bbc_pkg::*;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  handle;
    logic [23:0] block_number;
  } access_t;

  typedef struct {
    logic [3:0]  slot;
    logic        hit;
    logic        fill_needed;
    logic        evicted;
    logic [7:0]  evict_handle;
    logic [23:0] evict_block;
    logic        writeback_needed;
    logic [4:0]  invalidated_count;
  } outcome_t;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic [4:0] cfg_data = '0;
  logic cfg_ready;
  logic in_valid = 0;
  logic in_ready;
  logic in_accepted = 0;
  logic [1:0] func = '0;
  logic [7:0] handle = '0;
  logic [23:0] block_number = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [3:0] slot;
  logic hit, fill_needed, evicted, writeback_needed;
  logic [7:0] evict_handle;
  logic [23:0] evict_block;
  logic [4:0] invalidated_count;

  block_buffer_cache_fifo_unit DUT (.*);

  // predictor state
  logic        tag_valid [NSLOT];
  logic [7:0]  tag_owner [NSLOT];
  logic [23:0] tag_block [NSLOT];
  logic        tag_dirty [NSLOT];
  int          victim_ptr;
  logic [4:0]  active_setting;

  access_t  pending_words[$];
  outcome_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  initial forever #5 clk = ~clk;

  function automatic outcome_t predict_access(access_t a);
    outcome_t r;
    int n, s, cleared;
    logic found;
    r = '{default: '0};
    n = int'(active_setting);
    if (n < 1) n = 1;
    if (n > NSLOT) n = NSLOT;
    if (a.func == FUNC_INVAL) begin
      cleared = 0;
      for (int i = 0; i < n; i++)
        if (tag_valid[i] && tag_owner[i] == a.handle) begin
          tag_valid[i] = 0;
          tag_dirty[i] = 0;
          cleared++;
        end
      r.invalidated_count = (cleared > 31) ? 5'd31 : 5'(cleared);
      return r;
    end
    if (a.func == FUNC_NONE) return r;
    found = 0;
    s = 0;
    for (int i = 0; i < NSLOT; i++)
      if (!found && tag_valid[i] && tag_owner[i] == a.handle
          && tag_block[i] == a.block_number) begin
        found = 1;
        s = i;
      end
    if (found) begin
      r.hit = 1;
    end else begin
      victim_ptr = victim_ptr + 1;
      if (victim_ptr >= n) victim_ptr = 0;
      s = victim_ptr;
      if (tag_valid[s]) begin
        r.evicted = 1;
        r.evict_handle = tag_owner[s];
        r.evict_block = tag_block[s];
        r.writeback_needed = tag_dirty[s];
      end
      tag_valid[s] = 1;
      tag_owner[s] = a.handle;
      tag_block[s] = a.block_number;
      tag_dirty[s] = 0;
      r.fill_needed = 1;
    end
    if (a.func == FUNC_WRITE) tag_dirty[s] = 1;
    r.slot = s[3:0];
    return r;
  endfunction

  // remember whether the offered word was taken at this rising edge
  always @(posedge clk) begin
    in_accepted <= !rst && in_valid && in_ready;
  end

  // driver: present next word on falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_accepted) begin
      // previous word (if any) was taken at the last rising edge
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1;
        func <= pending_words[0].func;
        handle <= pending_words[0].handle;
        block_number <= pending_words[0].block_number;
        void'(pending_words.pop_front());
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver readiness, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // input acceptance feeds the predictor
  always @(posedge clk) begin
    access_t a;
    if (!rst && in_valid && in_ready) begin
      a.func = func;
      a.handle = handle;
      a.block_number = block_number;
      expected_results.push_back(predict_access(a));
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result slot=%0d hit=%0d", $time, slot, hit);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if ({slot, hit, fill_needed, evicted, evict_handle, evict_block,
             writeback_needed, invalidated_count} !==
            {e.slot, e.hit, e.fill_needed, e.evicted, e.evict_handle, e.evict_block,
             e.writeback_needed, e.invalidated_count}) begin
          $display("%0t: mismatch expected slot=%0d hit=%0d fill=%0d ev=%0d eh=%0h eb=%0h wb=%0d cnt=%0d",
                   $time, e.slot, e.hit, e.fill_needed, e.evicted, e.evict_handle,
                   e.evict_block, e.writeback_needed, e.invalidated_count);
          $display("%0t:          actual slot=%0d hit=%0d fill=%0d ev=%0d eh=%0h eb=%0h wb=%0d cnt=%0d",
                   $time, slot, hit, fill_needed, evicted, evict_handle,
                   evict_block, writeback_needed, invalidated_count);
          errors++;
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_word(logic [1:0] f, logic [7:0] h, logic [23:0] b);
    access_t a;
    a.func = f;
    a.handle = h;
    a.block_number = b;
    pending_words.push_back(a);
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(logic [4:0] v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    active_setting = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // random traffic: small handle/block pools so hits and invalidates land
  task automatic add_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 4)
        add_word(FUNC_NONE, 8'($urandom), 24'($urandom));
      else if (k < 12)
        add_word(FUNC_INVAL, 8'($urandom_range(3)), 24'($urandom));
      else if (k < 20)
        add_word(2'($urandom_range(1)), 8'($urandom), 24'($urandom));
      else
        add_word(2'($urandom_range(1)), 8'($urandom_range(3)), 24'($urandom_range(12)));
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tag_valid[i] = 0;
      tag_dirty[i] = 0;
      tag_owner[i] = '0;
      tag_block[i] = '0;
    end
    victim_ptr = 0;
    active_setting = ACTIVE_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, each function, dirty eviction, unused code
    add_word(FUNC_READ, 8'h00, 24'h000000);
    add_word(FUNC_WRITE, 8'hFF, 24'hFFFFFF);
    add_word(FUNC_READ, 8'hFF, 24'hFFFFFF);
    add_word(FUNC_WRITE, 8'h00, 24'h000000);
    add_word(FUNC_NONE, 8'hFF, 24'hFFFFFF);
    add_word(FUNC_INVAL, 8'hFF, 24'h0);
    add_word(FUNC_INVAL, 8'h55, 24'h0);
    for (int i = 0; i < 17; i++) add_word(FUNC_WRITE, 8'hAA, 24'(i));
    wait_idle();

    // small active count: wrap and eviction churn; high slots still hit
    write_active(5'd2);
    add_word(FUNC_READ, 8'hAA, 24'd10);
    add_word(FUNC_READ, 8'h01, 24'd1);
    add_word(FUNC_INVAL, 8'hAA, 24'd0);
    add_random(200);
    wait_idle();

    write_active(5'd0);
    add_random(100);
    wait_idle();

    // above range acts as the full set; sender sparse
    write_active(5'd31);
    send_idle_pct = 75;
    add_random(250);
    wait_idle();

    write_active(5'd16);
    send_idle_pct = 0;
    recv_stall_pct = 75;
    add_random(250);
    wait_idle();

    write_active(5'd7);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    add_random(300);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    write_active(5'd1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    add_random(150);
    wait_idle();

    write_active(5'd16);
    add_random(330);
    wait_idle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
